@@ rtl/core/usb_ohci_pkg.sv @@
// Package for the OHCI register block: payload structs, codes and register constants.
// No dependencies.
package usb_ohci_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic [3:0]  port_index;
    logic        low_speed;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } out_item_t;

  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_ATTACH = 3'd2;
  localparam logic [2:0] KIND_DETACH = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  localparam int NREGS = 20;
  localparam logic [4:0] RG_REV   = 5'd0;
  localparam logic [4:0] RG_CTRL  = 5'd1;
  localparam logic [4:0] RG_CMD   = 5'd2;
  localparam logic [4:0] RG_ISTAT = 5'd3;
  localparam logic [4:0] RG_IEN   = 5'd4;
  localparam logic [4:0] RG_FMINT = 5'd12;
  localparam logic [4:0] RG_FMNUM = 5'd14;
  localparam logic [4:0] RG_LSTH  = 5'd16;
  localparam logic [4:0] RG_RHDA  = 5'd17;

  localparam logic [11:0] PORT_BASE = 12'h054;
  localparam logic [31:0] REV_RESET   = 32'h10;
  localparam logic [31:0] FMINT_RESET = 32'h2EDF;
  localparam logic [31:0] LSTH_RESET  = 32'h628;
  localparam logic [31:0] RHDA_RESET  = 32'h0100_0000;

  localparam logic [31:0] PS_CCS  = 32'h1;
  localparam logic [31:0] PS_PES  = 32'h2;
  localparam logic [31:0] PS_PSS  = 32'h4;
  localparam logic [31:0] PS_PRS  = 32'h10;
  localparam logic [31:0] PS_PPS  = 32'h100;
  localparam logic [31:0] PS_LSDA = 32'h200;
  localparam logic [31:0] PS_CSC  = 32'h10000;
  localparam logic [31:0] PS_PESC = 32'h20000;
  localparam logic [31:0] PS_PSSC = 32'h40000;
  localparam logic [31:0] PS_CHG  = 32'h1F0000;
  localparam logic [31:0] PS_PRSC = 32'h100000;

  localparam logic [31:0] INT_RHSC = 32'h40;
  localparam logic [31:0] INT_MIE  = 32'h8000_0000;

  // Port word after a write; s_in is the stored word, conn the connection.
  function automatic logic [31:0] port_wr(logic [31:0] s_in, logic conn, logic [31:0] v);
    logic [31:0] s;
    s = s_in;
    if (v[0]) s = s & ~PS_PES;
    if (v[1] && conn) s = s | PS_PES;
    if (v[2] && (s & PS_PES) != 0) s = s | PS_PSS;
    if (v[3] && (s & PS_PSS) != 0) s = (s & ~PS_PSS) | PS_PSSC;
    if (v[4] && conn) s = (s & ~(PS_PRS | PS_PSS)) | PS_PRSC | PS_PES;
    if (v[8]) s = s | PS_PPS;
    if (v[9]) s = s & ~(PS_PPS | PS_PES);
    s = s & ~(v & PS_CHG);
    return s;
  endfunction

endpackage

@@ rtl/core/usb_ohci_port.sv @@
// One root-hub port: status word, connection and speed, with read view.
// Depends on usb_ohci_pkg.
module usb_ohci_port (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [31:0] wr_data,
  input  logic        attach,
  input  logic        detach,
  input  logic        low_speed,
  input  logic        ctl_reset,
  output logic [31:0] rd_view
);
  import usb_ohci_pkg::*;

  logic [31:0] status;
  logic        conn;
  logic        ls;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      conn   <= 1'b0;
      ls     <= 1'b0;
    end else if (ctl_reset) begin
      status <= conn ? (PS_CCS | PS_CSC | PS_PPS | (ls ? PS_LSDA : 32'h0)) : 32'h0;
    end else if (wr_en) begin
      status <= port_wr(status, conn, wr_data);
    end else if (attach) begin
      conn   <= 1'b1;
      ls     <= low_speed;
      status <= ((status | PS_CCS | PS_CSC | PS_PPS) & ~PS_LSDA)
                | (low_speed ? PS_LSDA : 32'h0);
    end else if (detach) begin
      conn   <= 1'b0;
      ls     <= 1'b0;
      status <= (status & ~(PS_CCS | PS_PES | PS_LSDA)) | PS_CSC | PS_PESC;
    end
  end

  always_comb begin
    if (conn) rd_view = ((status | PS_CCS | PS_PPS) & ~PS_LSDA) | (ls ? PS_LSDA : 32'h0);
    else      rd_view = status & ~(PS_CCS | PS_PES | PS_LSDA);
  end
endmodule

@@ rtl/core/usb_ohci_register_block_top.sv @@
// Top level of the OHCI register block: operational registers, ports, result register.
// Depends on usb_ohci_pkg and usb_ohci_port.
// The result appears in the cycle after its beat is accepted; throughput one beat per cycle while out_ready holds.
// The result register feeds out_valid; a new beat is taken whenever the result
// register is empty or being drained. rst (synchronous) restores reset values:
// num_ports 4, all ports disconnected.
module usb_ohci_register_block_top #(
  parameter int MAX_PORTS = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  usb_ohci_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output usb_ohci_pkg::out_item_t out_data,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_data
);
  import usb_ohci_pkg::*;

  logic [31:0] regs [NREGS];
  logic [3:0]  num_ports;
  logic [31:0] pview [MAX_PORTS];
  logic [MAX_PORTS-1:0] p_wr, p_att, p_det;

  logic        acc;
  logic        is_rd, is_wr;
  logic [11:0] off;
  logic [31:0] v;
  logic        reg_hit, port_hit;
  logic [4:0]  ridx;
  logic [9:0]  pword;
  logic [3:0]  pidx;
  logic        ev_ok;
  logic        ctl_reset;
  out_item_t   res_next;
  logic [31:0] rd;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;
  assign off      = in_data.offset;
  assign v        = in_data.write_data;
  assign is_rd    = in_data.kind == KIND_READ;
  assign is_wr    = in_data.kind == KIND_WRITE;
  assign reg_hit  = off < PORT_BASE && off[1:0] == 2'b00;
  assign ridx     = (off[6:2] <= 5'd5) ? ((off[6:2] == 5'd5) ? RG_IEN : off[6:2])
                                        : off[6:2] - 5'd1;
  assign pword    = off[11:2] - PORT_BASE[11:2];
  assign port_hit = off >= PORT_BASE
                    && {2'b00, off} < {2'b00, PORT_BASE} + {6'd0, num_ports, 2'b00}
                    && pword < 10'(MAX_PORTS);
  assign pidx     = pword[3:0];
  assign ev_ok    = {28'd0, in_data.port_index} < 32'(MAX_PORTS);
  assign ctl_reset = acc && is_wr && reg_hit && ridx == RG_CMD && v[0];

  genvar g;
  generate
    for (g = 0; g < MAX_PORTS; g++) begin : g_port
      assign p_wr[g]  = acc && is_wr && !reg_hit && port_hit && pidx == 4'(g);
      assign p_att[g] = acc && in_data.kind == KIND_ATTACH && in_data.port_index == 4'(g);
      assign p_det[g] = acc && in_data.kind == KIND_DETACH && in_data.port_index == 4'(g);
      usb_ohci_port u_port (
        .clk(clk), .rst(rst), .wr_en(p_wr[g]), .wr_data(v),
        .attach(p_att[g]), .detach(p_det[g]), .low_speed(in_data.low_speed),
        .ctl_reset(ctl_reset), .rd_view(pview[g])
      );
    end
  endgenerate

  always_comb begin
    rd = '0;
    if (reg_hit) rd = regs[ridx];
    else if (port_hit) rd = pview[pidx];
    res_next.read_data = is_rd ? rd : 32'h0;
    res_next.irq = (in_data.kind == KIND_ATTACH || in_data.kind == KIND_DETACH) && ev_ok
                   && (regs[RG_IEN] & INT_RHSC) != 0 && (regs[RG_IEN] & INT_MIE) != 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_ports <= 4'd4;
      for (int i = 0; i < NREGS; i++) regs[i] <= '0;
      regs[RG_REV]   <= REV_RESET;
      regs[RG_FMINT] <= FMINT_RESET;
      regs[RG_LSTH]  <= LSTH_RESET;
      regs[RG_RHDA]  <= RHDA_RESET | 32'd4;
    end else if (cfg_we) begin
      num_ports <= cfg_data;
      regs[RG_RHDA] <= {regs[RG_RHDA][31:8], 4'd0, cfg_data};
    end else if (acc) begin
      case (in_data.kind)
        KIND_WRITE: begin
          if (reg_hit) begin
            case (off[6:0])
              7'h08: begin
                if (v[0]) begin
                  for (int i = 0; i < NREGS; i++) regs[i] <= '0;
                  regs[RG_REV]   <= REV_RESET;
                  regs[RG_FMINT] <= FMINT_RESET;
                  regs[RG_LSTH]  <= LSTH_RESET;
                  regs[RG_RHDA]  <= RHDA_RESET | {28'd0, num_ports};
                  regs[RG_CMD]   <= v & ~32'h1;
                end else begin
                  regs[RG_CMD] <= regs[RG_CMD] | v;
                end
              end
              7'h0C: regs[RG_ISTAT] <= regs[RG_ISTAT] & ~v;
              7'h10: regs[RG_IEN] <= regs[RG_IEN] | v;
              7'h14: regs[RG_IEN] <= regs[RG_IEN] & ~v;
              7'h18: regs[ridx] <= v & ~32'hFF;
              7'h20, 7'h24, 7'h28, 7'h2C: regs[ridx] <= v & ~32'hF;
              7'h1C, 7'h30, 7'h38, 7'h3C: ;
              7'h48: regs[ridx] <= {v[31:8], regs[ridx][7:0]};
              default: regs[ridx] <= v;
            endcase
          end
        end
        KIND_ATTACH, KIND_DETACH: begin
          if (ev_ok) regs[RG_ISTAT] <= regs[RG_ISTAT] | INT_RHSC;
        end
        KIND_TICK: begin
          if (regs[RG_CTRL][7:6] == 2'd2)
            regs[RG_FMNUM] <= {16'd0, regs[RG_FMNUM][15:0] + 16'd1};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (acc) out_data <= res_next;
  end
endmodule
